>>> sv/brfb_pkg.sv
`timescale 1ns / 1ps

package brfb_pkg;

    localparam int unsigned CAP_W = 9;
    localparam int unsigned LEN_W = 4;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned NUM_BYTES = 8;
    localparam int unsigned CNT_W = 3;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [0:0] {
        OP_PUT = 1'b0,
        OP_GET = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_WRONGARG = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_PUT,
        S_GET
    } state_t;

    typedef struct packed {
        op_t                operation;
        logic [LEN_W-1:0]   burst_length;
        logic [BYTE_W-1:0]  data_byte_0;
        logic [BYTE_W-1:0]  data_byte_1;
        logic [BYTE_W-1:0]  data_byte_2;
        logic [BYTE_W-1:0]  data_byte_3;
        logic [BYTE_W-1:0]  data_byte_4;
        logic [BYTE_W-1:0]  data_byte_5;
        logic [BYTE_W-1:0]  data_byte_6;
        logic [BYTE_W-1:0]  data_byte_7;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [BYTE_W-1:0]  read_byte;
        logic               last;
        logic [CAP_W-1:0]   occupancy;
    } result_t;

    typedef struct packed {
        logic    load;
        logic    commit;
        logic    write;
        logic    read;
        logic    report;
        status_t report_status;
    } ctrl_cmd_t;

    typedef struct packed {
        status_t status;
        op_t     operation;
        logic    final_byte;
    } dp_status_t;

endpackage

>>> sv/brfb_ctrl.sv
`timescale 1ns / 1ps

module brfb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  brfb_pkg::dp_status_t dp_stat,
    output brfb_pkg::ctrl_cmd_t  cmd
);
    import brfb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (dp_stat.status != ST_OK)
                begin
                    state_next = S_IDLE;
                end
                else if (dp_stat.operation == OP_PUT)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_GET;
                end
            end
            S_PUT, S_GET:
            begin
                if (dp_stat.final_byte)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '{load: 1'b0, commit: 1'b0, write: 1'b0, read: 1'b0,
                report: 1'b0, report_status: ST_OK};
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                cmd.load = start;
            end
            S_EVAL:
            begin
                if (dp_stat.status != ST_OK)
                begin
                    cmd.report = 1'b1;
                    cmd.report_status = dp_stat.status;
                end
                else
                begin
                    cmd.commit = 1'b1;
                end
            end
            S_PUT:
            begin
                cmd.write = 1'b1;
                cmd.report = dp_stat.final_byte;
            end
            S_GET:
            begin
                cmd.read = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

>>> sv/brfb_datapath.sv
`timescale 1ns / 1ps

module brfb_datapath #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned MAX_BURST = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  brfb_pkg::item_t                item,
    input  logic                           cfg_we,
    input  logic [brfb_pkg::CAP_W-1:0]     cfg_wdata,
    input  brfb_pkg::ctrl_cmd_t            cmd,
    output brfb_pkg::dp_status_t           dp_stat,
    output logic                           strobe,
    output brfb_pkg::result_t              result
);
    import brfb_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned XW = (PW + 1 > CAP_W) ? PW + 1 : CAP_W;

    logic [BYTE_W-1:0] mem [DEPTH];

    logic [CAP_W-1:0]  capacity_reg;
    logic [PW-1:0]     rp_reg;
    logic [PW-1:0]     wp_reg;
    logic [CAP_W-1:0]  occ_reg;
    logic [CNT_W-1:0]  cnt_reg;
    item_t             item_reg;
    logic              strobe_reg;
    status_t           status_reg;
    logic              last_reg;
    logic              byte_sel_reg;
    logic [BYTE_W-1:0] rdata_reg;

    logic [XW-1:0]     cap_eff;
    logic [PW-1:0]     rp_next;
    logic [PW-1:0]     wp_next;
    logic [PW-1:0]     addr;
    logic [BYTE_W-1:0] wbyte;
    logic              bad_len;
    logic              no_room;
    status_t           status_now;
    logic              final_byte;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                              input logic [XW-1:0] cap);
        logic [XW-1:0] n;
        n = XW'(p) + XW'(1);
        return (n >= cap) ? '0 : n[PW-1:0];
    endfunction

    always_comb
    begin
        if (cfg_wdata == '0 && capacity_reg == '0)
        begin
            cap_eff = XW'(1);
        end
        else if (capacity_reg == '0)
        begin
            cap_eff = XW'(1);
        end
        else if (XW'(capacity_reg) > XW'(DEPTH))
        begin
            cap_eff = XW'(DEPTH);
        end
        else
        begin
            cap_eff = XW'(capacity_reg);
        end
    end

    assign rp_next = advance(rp_reg, cap_eff);
    assign wp_next = advance(wp_reg, cap_eff);

    always_comb
    begin
        case (cnt_reg)
            3'd0: wbyte = item_reg.data_byte_0;
            3'd1: wbyte = item_reg.data_byte_1;
            3'd2: wbyte = item_reg.data_byte_2;
            3'd3: wbyte = item_reg.data_byte_3;
            3'd4: wbyte = item_reg.data_byte_4;
            3'd5: wbyte = item_reg.data_byte_5;
            3'd6: wbyte = item_reg.data_byte_6;
            default: wbyte = item_reg.data_byte_7;
        endcase
    end

    assign bad_len = (item_reg.burst_length == '0)
                  || (item_reg.burst_length > LEN_W'(MAX_BURST));
    assign no_room = ((XW+1)'(occ_reg) + (XW+1)'(item_reg.burst_length))
                   > (XW+1)'(cap_eff);
    assign final_byte = ({1'b0, cnt_reg} == (item_reg.burst_length - LEN_W'(1)));

    always_comb
    begin
        if (bad_len)
        begin
            status_now = ST_WRONGARG;
        end
        else if (item_reg.operation == OP_PUT)
        begin
            status_now = no_room ? ST_FULL : ST_OK;
        end
        else if (occ_reg == '0)
        begin
            status_now = ST_EMPTY;
        end
        else if (occ_reg < CAP_W'(item_reg.burst_length))
        begin
            status_now = ST_RANGE;
        end
        else
        begin
            status_now = ST_OK;
        end
    end

    assign dp_stat = '{status: status_now, operation: item_reg.operation,
                       final_byte: final_byte};

    assign addr = cmd.write ? wp_reg : rp_reg;

    // single-port byte store
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[addr] <= wbyte;
        end
        if (cmd.read)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            rp_reg       <= '0;
            wp_reg       <= '0;
            occ_reg      <= '0;
            cnt_reg      <= '0;
            strobe_reg   <= 1'b0;
            status_reg   <= ST_OK;
            last_reg     <= 1'b0;
            byte_sel_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.report || cmd.read;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
                rp_reg       <= '0;
                wp_reg       <= '0;
                occ_reg      <= '0;
            end
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            if (cmd.commit)
            begin
                if (item_reg.operation == OP_PUT)
                begin
                    occ_reg <= occ_reg + CAP_W'(item_reg.burst_length);
                end
                else
                begin
                    occ_reg <= occ_reg - CAP_W'(item_reg.burst_length);
                end
            end
            if (cmd.write)
            begin
                wp_reg  <= wp_next;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.read)
            begin
                rp_reg       <= rp_next;
                cnt_reg      <= cnt_reg + CNT_W'(1);
                status_reg   <= ST_OK;
                last_reg     <= final_byte;
                byte_sel_reg <= 1'b1;
            end
            else if (cmd.report)
            begin
                status_reg   <= cmd.report_status;
                last_reg     <= 1'b1;
                byte_sel_reg <= 1'b0;
            end
        end
    end

    assign strobe = strobe_reg;
    assign result = '{status: status_reg,
                      read_byte: byte_sel_reg ? rdata_reg : '0,
                      last: last_reg,
                      occupancy: occ_reg};

endmodule

>>> sv/byte_ring_fifo_burst_unit.sv
`timescale 1ns / 1ps

// Circular byte FIFO taking put or get bursts of 1 to MAX_BURST bytes, all or
// nothing. An item is taken when start is high and busy is low; results then
// come out with strobe high for one cycle each and cannot be held off. A put
// or any refused item gives one result; an accepted get gives one result per
// byte in consecutive cycles, oldest first, last byte marked. Every result
// carries the occupancy after the item. An item is evaluated in the cycle
// after it is taken, then the single-port byte store moves one byte per
// cycle while busy stays high; the next item can be taken in the cycle its
// last result is shown. Writing capacity empties the ring; write it only when
// the block is idle and all results have been shown.
module byte_ring_fifo_burst_unit #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned MAX_BURST = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  brfb_pkg::item_t             item,
    input  logic                        cfg_we,
    input  logic [brfb_pkg::CAP_W-1:0]  cfg_wdata,
    output logic                        strobe,
    output brfb_pkg::result_t           result
);
    import brfb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_stat;

    brfb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .dp_stat (dp_stat),
        .cmd     (cmd)
    );

    brfb_datapath #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .dp_stat   (dp_stat),
        .strobe    (strobe),
        .result    (result)
    );

endmodule

>>> bench/tb_byte_ring_fifo_burst_unit.sv
`timescale 1ns / 1ps

module tb_byte_ring_fifo_burst_unit;

    import brfb_pkg::*;

    class burst_ring_model;
        logic [BYTE_W-1:0] ring_bytes [256];
        int                rd_ptr;
        int                wr_ptr;
        bit                ring_full;
        logic [CAP_W-1:0]  capacity;
        result_t           replies_due [$];
        int                errors;

        function new();
            rd_ptr = 0;
            wr_ptr = 0;
            ring_full = 1'b0;
            capacity = CAP_RESET;
            errors = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
            rd_ptr = 0;
            wr_ptr = 0;
            ring_full = 1'b0;
        endfunction

        function int limit();
            if (capacity == 0)
                return 1;
            if (capacity > 256)
                return 256;
            return capacity;
        endfunction

        function int held();
            if (wr_ptr < rd_ptr)
                return limit() - (rd_ptr - wr_ptr);
            if (wr_ptr > rd_ptr)
                return wr_ptr - rd_ptr;
            return ring_full ? limit() : 0;
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction

        function int advance(int p);
            return (p + 1 >= limit()) ? 0 : p + 1;
        endfunction

        function void post(status_t st, logic [BYTE_W-1:0] b, logic is_last);
            result_t r;
            r.status = st;
            r.read_byte = b;
            r.last = is_last;
            r.occupancy = CAP_W'(held());
            replies_due.push_back(r);
        endfunction

        function void apply_burst(item_t it);
            int                len;
            int                occ;
            logic [63:0]       payload;
            logic [BYTE_W-1:0] taken [NUM_BYTES];
            len = it.burst_length;
            occ = held();
            payload = {it.data_byte_0, it.data_byte_1, it.data_byte_2, it.data_byte_3,
                       it.data_byte_4, it.data_byte_5, it.data_byte_6, it.data_byte_7};
            if (len == 0 || len > NUM_BYTES)
            begin
                post(ST_WRONGARG, '0, 1'b1);
                return;
            end
            if (it.operation == OP_PUT)
            begin
                if (ring_full || len + occ > limit())
                begin
                    post(ST_FULL, '0, 1'b1);
                    return;
                end
                for (int i = 0; i < len; i++)
                begin
                    ring_bytes[wr_ptr] = payload[63 - 8 * i -: 8];
                    wr_ptr = advance(wr_ptr);
                end
                if (wr_ptr == rd_ptr)
                    ring_full = 1'b1;
                post(ST_OK, '0, 1'b1);
                return;
            end
            if (occ == 0)
            begin
                post(ST_EMPTY, '0, 1'b1);
                return;
            end
            if (occ < len)
            begin
                post(ST_RANGE, '0, 1'b1);
                return;
            end
            for (int i = 0; i < len; i++)
            begin
                taken[i] = ring_bytes[rd_ptr];
                rd_ptr = advance(rd_ptr);
            end
            ring_full = 1'b0;
            for (int i = 0; i < len; i++)
                post(ST_OK, taken[i], i == len - 1);
        endfunction

        function void field_check(string name, logic [CAP_W-1:0] e, logic [CAP_W-1:0] a);
            if (e !== a)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
            end
        endfunction

        function void compare_reply(result_t got);
            result_t want;
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual status %0d byte %0d",
                         $time, got.status, got.read_byte);
                return;
            end
            want = replies_due.pop_front();
            field_check("status", CAP_W'(want.status), CAP_W'(got.status));
            field_check("read_byte", CAP_W'(want.read_byte), CAP_W'(got.read_byte));
            field_check("last", CAP_W'(want.last), CAP_W'(got.last));
            field_check("occupancy", want.occupancy, got.occupancy);
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    item_t            item;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;
    logic             strobe;
    result_t          result;

    burst_ring_model  model;

    byte_ring_fifo_burst_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .strobe    (strobe),
        .result    (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
                model.compare_reply(result);
            if (start && !busy)
                model.apply_burst(item);
            if (cfg_we)
                model.set_capacity(cfg_wdata);
        end
    end

    function automatic item_t make_burst(op_t op, int len, logic [63:0] payload);
        item_t it;
        it.operation = op;
        it.burst_length = LEN_W'(len);
        {it.data_byte_0, it.data_byte_1, it.data_byte_2, it.data_byte_3,
         it.data_byte_4, it.data_byte_5, it.data_byte_6, it.data_byte_7} = payload;
        return it;
    endfunction

    function automatic item_t random_burst();
        int  put_pct;
        int  pick;
        int  len;
        op_t op;
        put_pct = (model.held() < model.limit() / 2) ? 65 : 35;
        op = ($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_GET;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            len = 0;
        else if (pick < 12)
            len = $urandom_range(9, 15);
        else if (pick < 25 && op == OP_GET && model.held() >= 1 && model.held() <= 8)
            len = model.held();
        else
            len = $urandom_range(1, 8);
        return make_burst(op, len, {$urandom, $urandom});
    endfunction

    task automatic send_burst(input item_t it, input bit allow_idle);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (allow_idle && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (model.outstanding() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int count,
                             input bit allow_idle, input bit fill_first);
        write_capacity(cap);
        if (fill_first)
            for (int i = 0; i < 32; i++)
                send_burst(make_burst(OP_PUT, 8, {$urandom, $urandom}), allow_idle);
        for (int i = 0; i < count; i++)
            send_burst(random_burst(), allow_idle);
    endtask

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        model = new();
        rst_n <= 1'b0;
        start <= 1'b0;
        item <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacity: refusals, extremes of data, range check
        send_burst(make_burst(OP_GET, 1, '0), 1'b1);
        send_burst(make_burst(OP_PUT, 0, '1), 1'b1);
        send_burst(make_burst(OP_GET, 0, '0), 1'b1);
        send_burst(make_burst(OP_PUT, 15, '1), 1'b1);
        send_burst(make_burst(OP_PUT, 8, '1), 1'b1);
        send_burst(make_burst(OP_PUT, 8, '0), 1'b1);
        send_burst(make_burst(OP_GET, 9, '0), 1'b1);
        send_burst(make_burst(OP_GET, 8, '0), 1'b1);
        send_burst(make_burst(OP_GET, 8, '1), 1'b1);
        send_burst(make_burst(OP_PUT, 3, 64'hA55A_C33C_0F_F0_1234), 1'b1);
        send_burst(make_burst(OP_GET, 5, '0), 1'b1);
        send_burst(make_burst(OP_GET, 3, '0), 1'b1);

        // small ring: overflow, full flag, pointer wrap, drop on write
        write_capacity(9'd5);
        send_burst(make_burst(OP_PUT, 4, 64'h0102_0304_0506_0708), 1'b1);
        send_burst(make_burst(OP_PUT, 2, 64'h1112_1314_1516_1718), 1'b1);
        send_burst(make_burst(OP_PUT, 1, 64'h2122_2324_2526_2728), 1'b1);
        send_burst(make_burst(OP_PUT, 1, 64'h3132_3334_3536_3738), 1'b1);
        send_burst(make_burst(OP_GET, 3, '0), 1'b1);
        send_burst(make_burst(OP_PUT, 3, 64'h4142_4344_4546_4748), 1'b1);
        send_burst(make_burst(OP_GET, 5, '0), 1'b1);
        send_burst(make_burst(OP_GET, 1, '0), 1'b1);
        send_burst(make_burst(OP_PUT, 2, 64'h5152_5354_5556_5758), 1'b1);
        write_capacity(9'd1);
        send_burst(make_burst(OP_GET, 1, '0), 1'b1);
        send_burst(make_burst(OP_PUT, 1, 64'hAA00_0000_0000_0000), 1'b1);
        send_burst(make_burst(OP_PUT, 1, 64'h5500_0000_0000_0000), 1'b1);
        send_burst(make_burst(OP_GET, 1, '0), 1'b1);

        run_phase(9'd511, 9, 1'b1, 1'b1);
        run_phase(9'd0, 9, 1'b1, 1'b0);
        run_phase(9'd3, 9, 1'b1, 1'b0);
        run_phase(9'd9, 9, 1'b1, 1'b0);
        run_phase(CAP_W'($urandom_range(1, 256)), 9, 1'b1, 1'b0);
        run_phase(9'd256, 9, 1'b0, 1'b0);

        settle();
        repeat (12) @(posedge clk);
        if (model.errors == 0 && model.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
sv/brfb_pkg.sv
sv/brfb_ctrl.sv
sv/brfb_datapath.sv
sv/byte_ring_fifo_burst_unit.sv
bench/tb_byte_ring_fifo_burst_unit.sv
